// ----- rtl/bam_pkg.sv -----
// Shared types, constants and register codes of the block-average glyph mapper.
package bam_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_CHUNK_DEF = 64;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int GLYPH_LIMIT   = 256;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHUNK_SIZE   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GLYPH_COUNT  = 8'd3;

   localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
   localparam logic [6:0]  CHUNK_SIZE_RST   = 7'd12;
   localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [11:0] chunk_col;
      logic [11:0] chunk_row;
      logic [7:0]  avg_red;
      logic [7:0]  avg_green;
      logic [7:0]  avg_blue;
      logic [7:0]  avg_alpha;
      logic [7:0]  glyph_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_GLYPH
   } state_type;

endpackage

// ----- rtl/bam_serial_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module bam_serial_div #(
   parameter int NW = 20,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic          done,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign fits  = trial >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= CW'(NW);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[NW-2:0], fits};
         rem_ff <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      end
   end

   assign busy = (cnt_ff != '0) || done_ff;
   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/block_average_glyph_mapper.sv -----
// Pixels are taken one at a time: a new pixel is accepted only once the state machine is back in idle.
// A pixel that completes a chunk also runs the serial averages and the glyph step before it returns.
// Reset: a clearing pass zeroes the column-sum memory, then pixels are taken.
// A register write re-derives chunk position and chunk counts in a serial pass.
// The output register holds one result, so the next pixel is taken while it waits.
module block_average_glyph_mapper #(
   parameter int MAX_WIDTH = bam_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHUNK = bam_pkg::MAX_CHUNK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bam_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bam_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bam_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int WW   = XW + 1;
   localparam int CSW  = $clog2(MAX_CHUNK + 1);
   localparam int AW   = 2 * CSW;
   localparam int SUMW = 8 + $clog2(MAX_CHUNK * MAX_CHUNK);
   localparam int DW   = (WW > 13) ? WW : 13;
   localparam int NCH  = 5;

   // configuration
   logic [12:0] width_ff, height_ff;
   logic [6:0]  chunk_ff;
   logic [8:0]  glyph_ff;
   logic [WW-1:0]  w_eff;
   logic [12:0]    h_eff;
   logic [CSW-1:0] cs_eff;
   logic [8:0]     gc_eff;
   logic [AW-1:0]  area;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bam_pkg::IMAGE_WIDTH_RST;
         height_ff <= bam_pkg::IMAGE_HEIGHT_RST;
         chunk_ff  <= bam_pkg::CHUNK_SIZE_RST;
         glyph_ff  <= bam_pkg::GLYPH_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            bam_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            bam_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            bam_pkg::REG_CHUNK_SIZE:   chunk_ff  <= csr_data[6:0];
            bam_pkg::REG_GLYPH_COUNT:  glyph_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) w_eff = WW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(width_ff);
      if (height_ff == '0) h_eff = 13'd1;
      else if (32'(height_ff) > bam_pkg::HEIGHT_LIMIT) h_eff = 13'(bam_pkg::HEIGHT_LIMIT);
      else h_eff = height_ff;
      if (chunk_ff == '0) cs_eff = CSW'(1);
      else if (32'(chunk_ff) > MAX_CHUNK) cs_eff = CSW'(MAX_CHUNK);
      else cs_eff = CSW'(chunk_ff);
      if (glyph_ff == '0) gc_eff = 9'd1;
      else if (32'(glyph_ff) > bam_pkg::GLYPH_LIMIT) gc_eff = 9'(bam_pkg::GLYPH_LIMIT);
      else gc_eff = glyph_ff;
   end

   assign area = AW'(cs_eff * cs_eff);

   // position and chunk tracking
   logic [XW-1:0]  x_ff, x_in, cx_ff, cx_in;
   logic [11:0]    y_ff, y_in, cy_ff, cy_in;
   logic [CSW-1:0] xm_ff, xm_in, ym_ff, ym_in;
   logic [WW-1:0]  ncx_ff;
   logic [12:0]    ncy_ff;

   // re-derivation of chunk position after reset and register writes
   logic          recalc_start_ff;
   logic          rc_busy, rc_done, recalc_busy;
   logic [DW-1:0] q_x, q_y, q_w, q_h;
   logic [CSW-1:0] r_x, r_y;

   always_ff @(posedge clock) begin
      if (reset) recalc_start_ff <= 1'b1;
      else recalc_start_ff <= csr_valid;
   end

   assign recalc_busy = recalc_start_ff || rc_busy;

   bam_serial_div #(.NW(DW), .DW(CSW)) u_div_x (
      .clock(clock), .reset(reset), .start(recalc_start_ff), .num(DW'(x_ff)), .den(cs_eff),
      .busy(rc_busy), .done(rc_done), .quo(q_x), .rem(r_x));
   bam_serial_div #(.NW(DW), .DW(CSW)) u_div_y (
      .clock(clock), .reset(reset), .start(recalc_start_ff), .num(DW'(y_ff)), .den(cs_eff),
      .busy(), .done(), .quo(q_y), .rem(r_y));
   bam_serial_div #(.NW(DW), .DW(CSW)) u_div_w (
      .clock(clock), .reset(reset), .start(recalc_start_ff), .num(DW'(w_eff)), .den(cs_eff),
      .busy(), .done(), .quo(q_w), .rem());
   bam_serial_div #(.NW(DW), .DW(CSW)) u_div_h (
      .clock(clock), .reset(reset), .start(recalc_start_ff), .num(DW'(h_eff)), .den(cs_eff),
      .busy(), .done(), .quo(q_h), .rem());

   // state machine
   bam_pkg::state_type state_ff, state_in;
   logic               accept, out_free, avg_start, avg_done, mem_we;
   logic [XW-1:0]      clr_addr_ff;
   logic               rsp_valid_ff;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // per-pixel latches
   bam_pkg::req_type pix_ff;
   logic [XW-1:0]    cxl_ff;
   logic [11:0]      cyl_ff;
   logic             in_area_ff, emit_ff, in_area, emit;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      avg_start = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         bam_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_addr_ff == XW'(MAX_WIDTH - 1)) state_in = bam_pkg::ST_IDLE;
         end
         bam_pkg::ST_IDLE: begin
            req_ready = !recalc_busy;
            if (req_valid && !recalc_busy) state_in = bam_pkg::ST_UPDATE;
         end
         bam_pkg::ST_UPDATE: begin
            mem_we    = in_area_ff;
            avg_start = in_area_ff && emit_ff;
            state_in  = avg_start ? bam_pkg::ST_DIVIDE : bam_pkg::ST_IDLE;
         end
         bam_pkg::ST_DIVIDE: begin
            if (avg_done) state_in = bam_pkg::ST_GLYPH;
         end
         bam_pkg::ST_GLYPH: begin
            if (out_free) state_in = bam_pkg::ST_IDLE;
         end
         default: state_in = bam_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bam_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bam_pkg::ST_CLEAR) clr_addr_ff <= clr_addr_ff + XW'(1);
      end
   end

   // position step
   always_comb begin
      in_area = ({1'b0, x_ff} < w_eff) && ({1'b0, y_ff} < h_eff)
                && ({1'b0, cx_ff} < ncx_ff) && ({1'b0, cy_ff} < ncy_ff);
      emit    = in_area && (xm_ff == cs_eff - CSW'(1)) && (ym_ff == cs_eff - CSW'(1));
      x_in = x_ff; cx_in = cx_ff; xm_in = xm_ff;
      y_in = y_ff; cy_in = cy_ff; ym_in = ym_ff;
      if (({1'b0, x_ff} + WW'(1)) >= w_eff) begin
         x_in = '0; cx_in = '0; xm_in = '0;
         if (({1'b0, y_ff} + 13'd1) >= h_eff) begin
            y_in = '0; cy_in = '0; ym_in = '0;
         end else begin
            y_in = y_ff + 12'd1;
            if (ym_ff + CSW'(1) == cs_eff) begin
               ym_in = '0; cy_in = cy_ff + 12'd1;
            end else begin
               ym_in = ym_ff + CSW'(1);
            end
         end
      end else begin
         x_in = x_ff + XW'(1);
         if (xm_ff + CSW'(1) == cs_eff) begin
            xm_in = '0; cx_in = cx_ff + XW'(1);
         end else begin
            xm_in = xm_ff + CSW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0; cx_ff <= '0; xm_ff <= '0;
         y_ff <= '0; cy_ff <= '0; ym_ff <= '0;
         ncx_ff <= '0; ncy_ff <= '0;
      end else if (rc_done) begin
         cx_ff  <= XW'(q_x);
         xm_ff  <= r_x;
         cy_ff  <= 12'(q_y);
         ym_ff  <= r_y;
         ncx_ff <= WW'(q_w);
         ncy_ff <= 13'(q_h);
      end else if (accept) begin
         x_ff <= x_in; cx_ff <= cx_in; xm_ff <= xm_in;
         y_ff <= y_in; cy_ff <= cy_in; ym_ff <= ym_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff     <= req_data;
         cxl_ff     <= cx_ff;
         cyl_ff     <= cy_ff;
         in_area_ff <= in_area;
         emit_ff    <= emit;
      end
   end

   // column-sum memory: red, green, blue, alpha, luma
   logic [NCH*SUMW-1:0] mem [MAX_WIDTH];
   logic [NCH*SUMW-1:0] rd_data, wr_data, new_word;
   logic [XW-1:0]       wr_addr;
   logic [SUMW-1:0]     new_sum [NCH];
   logic [7:0]          add_val [NCH];
   logic [9:0]          pix_total;

   assign pix_total  = 10'(pix_ff.red) + 10'(pix_ff.green) + 10'(pix_ff.blue) + 10'(pix_ff.alpha);
   assign add_val[0] = pix_ff.red;
   assign add_val[1] = pix_ff.green;
   assign add_val[2] = pix_ff.blue;
   assign add_val[3] = pix_ff.alpha;
   assign add_val[4] = pix_total[9:2];

   for (genvar k = 0; k < NCH; k++) begin : g_sum
      logic [SUMW:0] total;
      assign total = {1'b0, rd_data[k*SUMW +: SUMW]} + (SUMW + 1)'(add_val[k]);
      assign new_sum[k] = total[SUMW] ? '1 : total[SUMW-1:0];
      assign new_word[k*SUMW +: SUMW] = new_sum[k];
   end

   assign wr_addr = (state_ff == bam_pkg::ST_CLEAR) ? clr_addr_ff : cxl_ff;
   assign wr_data = ((state_ff == bam_pkg::ST_CLEAR) || emit_ff) ? '0 : new_word;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data <= mem[cx_ff];
   end

   // chunk averages
   logic [SUMW-1:0] avg_q [NCH];
   logic [7:0]      avg_sat [NCH];
   logic [7:0]      avg_ff [NCH];
   logic [16:0]     prod_ff;

   for (genvar k = 0; k < NCH; k++) begin : g_avg
      if (k == 0) begin : g_lead
         bam_serial_div #(.NW(SUMW), .DW(AW)) u_div (
            .clock(clock), .reset(reset), .start(avg_start), .num(new_sum[k]), .den(area),
            .busy(), .done(avg_done), .quo(avg_q[k]), .rem());
      end else begin : g_rest
         bam_serial_div #(.NW(SUMW), .DW(AW)) u_div (
            .clock(clock), .reset(reset), .start(avg_start), .num(new_sum[k]), .den(area),
            .busy(), .done(), .quo(avg_q[k]), .rem());
      end
      assign avg_sat[k] = (avg_q[k] > SUMW'(255)) ? 8'hFF : avg_q[k][7:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == bam_pkg::ST_DIVIDE && avg_done) begin
         for (int k = 0; k < NCH; k++) avg_ff[k] <= avg_sat[k];
         prod_ff <= 17'(gc_eff * avg_sat[4]);
      end
   end

   // glyph index: product divided by 255 with one correction step
   logic [16:0] est, resid;
   logic [8:0]  gq, glyph;

   always_comb begin
      est   = (prod_ff + (prod_ff >> 8)) >> 8;
      resid = prod_ff - 17'(est * 17'd255);
      gq    = (resid >= 17'd255) ? 9'(est + 17'd1) : 9'(est);
      glyph = (gq > gc_eff - 9'd1) ? gc_eff - 9'd1 : gq;
   end

   // output register
   bam_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == bam_pkg::ST_GLYPH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bam_pkg::ST_GLYPH && out_free) begin
         rsp_ff.chunk_col   <= 12'(cxl_ff);
         rsp_ff.chunk_row   <= cyl_ff;
         rsp_ff.avg_red     <= avg_ff[0];
         rsp_ff.avg_green   <= avg_ff[1];
         rsp_ff.avg_blue    <= avg_ff[2];
         rsp_ff.avg_alpha   <= avg_ff[3];
         rsp_ff.glyph_index <= glyph[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_update_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == bam_pkg::ST_UPDATE |-> $past(accept))
      else $error("update without a transfer");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == bam_pkg::ST_CLEAR |-> !req_ready)
      else $error("transfer during memory clear");

   a_offsets_in_chunk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bam_pkg::ST_IDLE && !recalc_busy && !$past(csr_valid))
      |-> (xm_ff < cs_eff) && (ym_ff < cs_eff))
      else $error("chunk offset out of range");

   a_emit_starts_divide: assert property (@(posedge clock) disable iff (reset)
      avg_start |=> state_ff == bam_pkg::ST_DIVIDE)
      else $error("average division not entered");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the block-average glyph mapper: directed table, register corner cases, then random frames.
module tb;

   localparam int WATCHDOG_LIMIT = 30000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   bam_pkg::req_type req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   bam_pkg::rsp_type rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [bam_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bam_pkg::CSR_DATA_W-1:0]  csr_data;

   // mirror of the block's registers and column sums
   logic [12:0] cfg_width;
   logic [12:0] cfg_height;
   logic [6:0]  cfg_chunk;
   logic [8:0]  cfg_glyphs;
   int unsigned next_col;
   int unsigned next_row;
   int unsigned sum_red   [bam_pkg::MAX_WIDTH_DEF];
   int unsigned sum_green [bam_pkg::MAX_WIDTH_DEF];
   int unsigned sum_blue  [bam_pkg::MAX_WIDTH_DEF];
   int unsigned sum_alpha [bam_pkg::MAX_WIDTH_DEF];
   int unsigned sum_luma  [bam_pkg::MAX_WIDTH_DEF];

   bam_pkg::rsp_type pending_chunks[$];
   int      mismatches;
   int      stray_results;
   int      quiet_cycles;
   bit      steady;

   typedef struct {
      bam_pkg::req_type pixel;
      bit               typed;
      bam_pkg::rsp_type chunk;
   } stim_row;

   stim_row directed[$];

   block_average_glyph_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned add_sat(int unsigned acc, int unsigned v);
      longint unsigned s;
      s = longint'(acc) + longint'(v);
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [7:0] avg_sat(int unsigned sum, int unsigned area);
      int unsigned q;
      q = sum / area;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // advance the mirror by one pixel; report a completed chunk
   function automatic bit accumulate_pixel(bam_pkg::req_type p, output bam_pkg::rsp_type chunk);
      int unsigned w, h, cs, gc, x, y, cx, cy, area, lum, gi;
      bit done;
      w  = clamp_cfg(cfg_width, bam_pkg::MAX_WIDTH_DEF);
      h  = clamp_cfg(cfg_height, bam_pkg::HEIGHT_LIMIT);
      cs = clamp_cfg(cfg_chunk, bam_pkg::MAX_CHUNK_DEF);
      gc = clamp_cfg(cfg_glyphs, bam_pkg::GLYPH_LIMIT);
      x  = next_col;
      y  = next_row;
      cx = x / cs;
      cy = y / cs;
      done  = 1'b0;
      chunk = '0;
      if (x < w && y < h && cx < w / cs && cy < h / cs) begin
         sum_red[cx]   = add_sat(sum_red[cx], p.red);
         sum_green[cx] = add_sat(sum_green[cx], p.green);
         sum_blue[cx]  = add_sat(sum_blue[cx], p.blue);
         sum_alpha[cx] = add_sat(sum_alpha[cx], p.alpha);
         sum_luma[cx]  = add_sat(sum_luma[cx],
                                 (int'(p.red) + p.green + p.blue + p.alpha) / 4);
         if (x % cs == cs - 1 && y % cs == cs - 1) begin
            area = cs * cs;
            lum  = avg_sat(sum_luma[cx], area);
            gi   = gc * lum / 255;
            if (gi > gc - 1) gi = gc - 1;
            chunk.chunk_col   = cx[11:0];
            chunk.chunk_row   = cy[11:0];
            chunk.avg_red     = avg_sat(sum_red[cx], area);
            chunk.avg_green   = avg_sat(sum_green[cx], area);
            chunk.avg_blue    = avg_sat(sum_blue[cx], area);
            chunk.avg_alpha   = avg_sat(sum_alpha[cx], area);
            chunk.glyph_index = gi[7:0];
            sum_red[cx]   = 0;
            sum_green[cx] = 0;
            sum_blue[cx]  = 0;
            sum_alpha[cx] = 0;
            sum_luma[cx]  = 0;
            done = 1'b1;
         end
      end
      if (x + 1 >= w) begin
         next_col = 0;
         next_row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         next_col = x + 1;
      end
      return done;
   endfunction

   task automatic hold_off();
      if (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
   endtask

   task automatic send_pixel(bam_pkg::req_type p, bit typed = 1'b0,
                             bam_pkg::rsp_type typed_chunk = '0);
      bam_pkg::rsp_type chunk;
      hold_off();
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      if (accumulate_pixel(p, chunk))
         pending_chunks.push_back(typed ? typed_chunk : chunk);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [bam_pkg::CSR_INDEX_W-1:0] idx,
                            logic [bam_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bam_pkg::REG_IMAGE_WIDTH:  cfg_width  = value;
         bam_pkg::REG_IMAGE_HEIGHT: cfg_height = value;
         bam_pkg::REG_CHUNK_SIZE:   cfg_chunk  = value[6:0];
         bam_pkg::REG_GLYPH_COUNT:  cfg_glyphs = value[8:0];
         default: ;
      endcase
   endtask

   task automatic configure(int w, int h, int cs, int gc);
      drain();
      write_reg(bam_pkg::REG_IMAGE_WIDTH, bam_pkg::CSR_DATA_W'(w));
      write_reg(bam_pkg::REG_IMAGE_HEIGHT, bam_pkg::CSR_DATA_W'(h));
      write_reg(bam_pkg::REG_CHUNK_SIZE, bam_pkg::CSR_DATA_W'(cs));
      write_reg(bam_pkg::REG_GLYPH_COUNT, bam_pkg::CSR_DATA_W'(gc));
      csr_valid <= 1'b0;
   endtask

   function automatic bam_pkg::req_type random_pixel();
      case ($urandom_range(5))
         0: return '1;
         1: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_row(bam_pkg::req_type p, bit typed, bam_pkg::rsp_type c);
      stim_row r;
      r.pixel = p;
      r.typed = typed;
      r.chunk = c;
      directed.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 29);
         if (rsp_valid && rsp_ready) begin
            if (pending_chunks.size() == 0) begin
               stray_results++;
               if (mismatches + stray_results <= 10)
                  $display("unexpected result %p", rsp_data);
            end else begin
               bam_pkg::rsp_type want;
               want = pending_chunks.pop_front();
               if (rsp_data.chunk_col !== want.chunk_col ||
                   rsp_data.chunk_row !== want.chunk_row ||
                   rsp_data.avg_red !== want.avg_red ||
                   rsp_data.avg_green !== want.avg_green ||
                   rsp_data.avg_blue !== want.avg_blue ||
                   rsp_data.avg_alpha !== want.avg_alpha ||
                   rsp_data.glyph_index !== want.glyph_index) begin
                  mismatches++;
                  if (mismatches + stray_results <= 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int w, h, cs, gc, n;
      bam_pkg::rsp_type c;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      mismatches    = 0;
      stray_results = 0;
      quiet_cycles  = 0;
      steady        = 1'b0;
      cfg_width  = bam_pkg::IMAGE_WIDTH_RST;
      cfg_height = bam_pkg::IMAGE_HEIGHT_RST;
      cfg_chunk  = bam_pkg::CHUNK_SIZE_RST;
      cfg_glyphs = bam_pkg::GLYPH_COUNT_RST;
      next_col = 0;
      next_row = 0;
      for (int i = 0; i < bam_pkg::MAX_WIDTH_DEF; i++) begin
         sum_red[i] = 0; sum_green[i] = 0; sum_blue[i] = 0; sum_alpha[i] = 0; sum_luma[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 2x2 image of 1x1 chunks: every pixel completes a chunk
      c = '{12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      add_row('1, 1'b1, c);
      c = '{12'd1, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      add_row('0, 1'b1, c);
      c = '{12'd0, 12'd1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd63};
      add_row('{8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1, c);
      c = '{12'd1, 12'd1, 8'd0, 8'd0, 8'd0, 8'd255, 8'd63};
      add_row('{8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, c);
      add_row('{8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, c);
      add_row('{8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b0, c);
      add_row('{8'h01, 8'h02, 8'h04, 8'h80}, 1'b0, c);
      add_row('{8'hFE, 8'hFD, 8'hFB, 8'h7F}, 1'b0, c);
      configure(2, 2, 1, 256);
      foreach (directed[i]) send_pixel(directed[i].pixel, directed[i].typed, directed[i].chunk);

      // all-zero registers act as 1: one glyph level, every pixel a chunk
      configure(0, 0, 0, 0);
      for (int i = 0; i < 4; i++) send_pixel(random_pixel());
      // oversized registers: 4096 wide, chunk 64, 256 levels, one row so no chunk
      configure(8191, 1, 127, 511);
      for (int i = 0; i < 6; i++) send_pixel(random_pixel());
      // partial edge chunks
      configure(5, 5, 2, 255);
      for (int i = 0; i < 25; i++) send_pixel(random_pixel());
      // large chunk, once
      configure(16, 16, 16, 7);
      for (int i = 0; i < 256; i++) send_pixel(random_pixel());

      for (int done = 0; done < 350; ) begin
         w  = $urandom_range(1, 12);
         h  = $urandom_range(1, 8);
         cs = $urandom_range(1, 4);
         gc = ($urandom_range(9) == 0) ? 511 : $urandom_range(1, 256);
         n  = $urandom_range(20, 60);
         configure(w, h, cs, gc);
         steady = (done >= 120 && done < 220);
         for (int i = 0; i < n; i++) send_pixel(random_pixel());
         done += n;
      end
      steady = 1'b0;
      drain();
      if (mismatches == 0 && stray_results == 0 && pending_chunks.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
